// ----- design/hfe_pkg.sv -----
package hfe_pkg;

    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h8408;

    localparam logic REG_EMIT_OPEN_FLAG = 1'b0;

    typedef struct packed {
        logic        open_flag;
        logic        raw;
        logic        last;
        logic [7:0]  data;
        logic [15:0] fcs;
    } t_job;

    typedef struct packed {
        logic [7:0] data;
        logic       fend;
    } t_line;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- design/hfe_queue.sv -----
module hfe_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         wr, rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= ~r_wp;
            end
            if (rd) begin
                r_rp <= ~r_rp;
            end
            case ({wr, rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

// ----- design/hfe_front.sv -----
module hfe_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_payload_byte,
    input  logic          i_last_payload,
    input  logic          i_emit_open_flag,
    output hfe_pkg::t_job o_job
);
    import hfe_pkg::*;

    logic [15:0] r_crc, n_crc;
    logic        r_start;
    logic [15:0] crc_next;

    assign crc_next        = crc_update(r_crc, i_payload_byte);
    assign o_job.open_flag = r_start && i_emit_open_flag;
    assign o_job.raw       = r_start;
    assign o_job.last      = i_last_payload;
    assign o_job.data      = i_payload_byte;
    assign o_job.fcs       = ~crc_next;
    assign n_crc           = i_last_payload ? CRC_INIT : crc_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= CRC_INIT;
            r_start <= 1'b1;
        end else if (i_accept) begin
            r_crc   <= n_crc;
            r_start <= i_last_payload;
        end
    end
endmodule

// ----- design/hfe_back.sv -----
module hfe_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  hfe_pkg::t_job  i_job,
    output logic           o_job_pop,
    input  logic           i_out_full,
    output logic           o_out_push,
    output hfe_pkg::t_line o_out
);
    import hfe_pkg::*;

    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_OPEN  = 3'd1;
    localparam logic [2:0] PH_DATA  = 3'd2;
    localparam logic [2:0] PH_CRCL  = 3'd3;
    localparam logic [2:0] PH_CRCH  = 3'd4;
    localparam logic [2:0] PH_CLOSE = 3'd5;

    logic [2:0] r_phase, n_phase;
    logic       r_sub, n_sub;
    logic [2:0] phase;
    logic [7:0] sel;
    logic       escapable, need_esc, go, done;

    assign phase = (r_phase == PH_START) ? (i_job.open_flag ? PH_OPEN : PH_DATA) : r_phase;
    assign go    = i_job_valid && !i_out_full;

    always_comb begin
        case (phase)
            PH_DATA: sel = i_job.data;
            PH_CRCL: sel = i_job.fcs[7:0];
            PH_CRCH: sel = i_job.fcs[15:8];
            default: sel = FLAG_BYTE;
        endcase
        escapable = ((phase == PH_DATA) && !i_job.raw) || (phase == PH_CRCL)
                    || (phase == PH_CRCH);
        need_esc  = escapable && ((sel == FLAG_BYTE) || (sel == ESC_BYTE));

        o_out.fend = (phase == PH_CLOSE);
        if (need_esc && !r_sub) begin
            o_out.data = ESC_BYTE;
        end else if (need_esc) begin
            o_out.data = sel ^ ESC_XOR;
        end else begin
            o_out.data = sel;
        end

        done    = 1'b0;
        n_phase = r_phase;
        n_sub   = r_sub;
        if (need_esc && !r_sub) begin
            n_sub   = 1'b1;
            n_phase = phase;
        end else begin
            n_sub = 1'b0;
            case (phase)
                PH_OPEN: n_phase = PH_DATA;
                PH_DATA: begin
                    if (i_job.last) begin
                        n_phase = PH_CRCL;
                    end else begin
                        n_phase = PH_START;
                        done    = 1'b1;
                    end
                end
                PH_CRCL: n_phase = PH_CRCH;
                PH_CRCH: n_phase = PH_CLOSE;
                default: begin
                    n_phase = PH_START;
                    done    = 1'b1;
                end
            endcase
        end
    end

    assign o_out_push = go;
    assign o_job_pop  = go && done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_sub   <= 1'b0;
        end else if (go) begin
            r_phase <= n_phase;
            r_sub   <= n_sub;
        end
    end
endmodule

// ----- design/hdlc_frame_encoder_crc16.sv -----
// HDLC-style frame encoder with CRC-16/X.25. Payload bytes are pushed one per transfer,
// the last one marked, and the framed line bytes come out of a queue-like result port:
// an optional opening flag, the first byte as is, later bytes and the two CRC bytes (low
// first) escaped, then a closing flag marked as frame end. Bytes enter while the job
// queue has room; the sequencer makes one line byte per cycle while the output queue
// has room. A byte costs a line byte plus one per opening flag or escape; a last byte
// adds the CRC bytes and the closing flag. A two-entry job queue between the classifier
// and the sequencer absorbs the difference. The open-flag register lies at address 0.
module hdlc_frame_encoder_crc16 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_last_payload,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_line_byte,
    output logic        o_frame_end,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hfe_pkg::*;

    logic  r_emit_open_flag;
    logic  accept;
    t_job  fr_job, bk_job;
    logic  jq_empty, job_pop;
    logic  oq_full, out_push;
    t_line bk_out, oq_out;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_EMIT_OPEN_FLAG) ? {31'd0, r_emit_open_flag} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_open_flag <= 1'b1;
        end else if (psel && penable && pwrite && (paddr[2] == REG_EMIT_OPEN_FLAG)) begin
            r_emit_open_flag <= pwdata[0];
        end
    end

    assign accept = push && !full;

    hfe_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_payload_byte   (i_payload_byte),
        .i_last_payload   (i_last_payload),
        .i_emit_open_flag (r_emit_open_flag),
        .o_job            (fr_job)
    );

    hfe_queue #(.W($bits(t_job))) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (fr_job),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_data  (bk_job),
        .o_empty (jq_empty)
    );

    hfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!jq_empty),
        .i_job       (bk_job),
        .o_job_pop   (job_pop),
        .i_out_full  (oq_full),
        .o_out_push  (out_push),
        .o_out       (bk_out)
    );

    hfe_queue #(.W($bits(t_line))) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (bk_out),
        .o_full  (oq_full),
        .i_pop   (pop),
        .o_data  (oq_out),
        .o_empty (empty)
    );

    assign o_line_byte = oq_out.data;
    assign o_frame_end = oq_out.fend;
endmodule

// ----- design/hfe_checker.sv -----
module hfe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_line_byte,
    input logic       o_frame_end,
    input logic       pready
);
    import hfe_pkg::*;

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    a_end_is_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_end) |-> (o_line_byte == FLAG_BYTE))
        else $error("frame end on a byte other than the flag");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_line_byte) && $stable(o_frame_end)))
        else $error("waiting result changed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");
endmodule

bind hdlc_frame_encoder_crc16 hfe_checker u_hfe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_line_byte (o_line_byte),
    .o_frame_end (o_frame_end),
    .pready      (pready)
);

// ----- bench/hfe_line_checker.sv -----
module hfe_line_checker
    import hfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  payload_byte,
    input  logic        last_payload,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  line_byte,
    input  logic        frame_end,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatch_count,
    output int          lines_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_line       line_bytes_due[$];
    logic [15:0] frame_crc;
    logic        frame_start;
    logic        open_flag_cfg;
    int          mismatches = 0;
    int          outstanding = 0;

    assign mismatch_count = mismatches;
    assign lines_pending  = outstanding;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic logic [15:0] crc_after(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {8'h00, b};
        repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    task automatic due_line(input logic [7:0] data, input logic fend);
        t_line entry;
        entry.data = data;
        entry.fend = fend;
        line_bytes_due.push_back(entry);
    endtask

    task automatic due_escaped(input logic [7:0] b);
        if (b == FLAG_BYTE || b == ESC_BYTE) begin
            due_line(ESC_BYTE, 1'b0);
            due_line(b ^ ESC_XOR, 1'b0);
        end else begin
            due_line(b, 1'b0);
        end
    endtask

    task automatic encode_payload(input logic [7:0] b, input logic last);
        logic [15:0] fcs;
        frame_crc = crc_after(frame_crc, b);
        if (frame_start) begin
            if (open_flag_cfg) begin
                due_line(FLAG_BYTE, 1'b0);
            end
            due_line(b, 1'b0);
            frame_start = 1'b0;
        end else begin
            due_escaped(b);
        end
        if (last) begin
            fcs = ~frame_crc;
            due_escaped(fcs[7:0]);
            due_escaped(fcs[15:8]);
            due_line(FLAG_BYTE, 1'b1);
            frame_crc   = CRC_INIT;
            frame_start = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_line want;
        if (!i_rst_n) begin
            frame_crc     = CRC_INIT;
            frame_start   = 1'b1;
            open_flag_cfg = 1'b1;
            line_bytes_due.delete();
        end else begin
            if (pop && !empty) begin
                if (line_bytes_due.size() == 0) begin
                    report_mismatch($sformatf("line byte %02h with nothing due", line_byte));
                end else begin
                    want = line_bytes_due.pop_front();
                    if (line_byte !== want.data) begin
                        report_mismatch($sformatf("line byte expected %02h, got %02h",
                                                  want.data, line_byte));
                    end
                    if (frame_end !== want.fend) begin
                        report_mismatch($sformatf("frame end expected %0b, got %0b on byte %02h",
                                                  want.fend, frame_end, line_byte));
                    end
                end
            end
            if (psel && penable && pwrite && pready && (paddr >> 2) == REG_EMIT_OPEN_FLAG) begin
                open_flag_cfg = pwdata[0];
            end
            if (push && !full) begin
                encode_payload(payload_byte, last_payload);
            end
        end
        outstanding <= line_bytes_due.size();
    end

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import hfe_pkg::*;

    localparam int         CYCLE_LIMIT    = 200000;
    localparam int         RX_HOLD_CYCLES = 400;
    localparam logic [2:0] OPEN_FLAG_ADDR = {REG_EMIT_OPEN_FLAG, 2'b00};
    localparam logic [2:0] UNUSED_ADDR    = 3'd4;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_payload_byte = 8'h00;
    logic        i_last_payload = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_line_byte;
    logic        o_frame_end;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    int mismatch_count;
    int lines_pending;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_requests = 0;
    int cycle_count = 0;

    hdlc_frame_encoder_crc16 DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_payload_byte (i_payload_byte),
        .i_last_payload (i_last_payload),
        .empty          (empty),
        .pop            (pop),
        .o_line_byte    (o_line_byte),
        .o_frame_end    (o_frame_end),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    hfe_line_checker u_line_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .payload_byte   (i_payload_byte),
        .last_payload   (i_last_payload),
        .empty          (empty),
        .pop            (pop),
        .line_byte      (o_line_byte),
        .frame_end      (o_frame_end),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .lines_pending  (lines_pending)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // The line side stalls at random, and for a long stretch whenever a hold is requested.
    initial begin
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        forever begin
            @(posedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push           <= 1'b1;
        i_payload_byte <= b;
        i_last_payload <= last;
        do @(posedge i_clk); while (full);
    endtask

    task automatic drain_lines();
        push <= 1'b0;
        do @(posedge i_clk); while (lines_pending != 0);
    endtask

    task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Frames are mostly short, with flag and escape values over-represented in the payload.
    task automatic send_random_frames(input int n_items);
        int          left;
        int          len;
        logic [7:0]  b;
        left = n_items;
        while (left > 0) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
            if (len > left) begin
                len = left;
            end
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(3) == 0) begin
                    b = $urandom_range(1) ? FLAG_BYTE : ESC_BYTE;
                end else begin
                    b = 8'($urandom_range(255));
                end
                send_byte(b, k == len - 1);
            end
            left -= len;
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_byte(8'h00, 1'b1);
        send_byte(FLAG_BYTE, 1'b1);
        send_byte(ESC_BYTE, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(ESC_BYTE, 1'b0);
        send_byte(FLAG_BYTE, 1'b0);
        send_byte(ESC_BYTE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(FLAG_BYTE, 1'b1);
        drain_lines();
        cfg_write(OPEN_FLAG_ADDR, 32'h0000_0000);
        send_byte(FLAG_BYTE, 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h11, 1'b0);
        drain_lines();
        // The flag setting only counts from the next frame start.
        cfg_write(OPEN_FLAG_ADDR, 32'hFFFF_FFFF);
        send_byte(8'h22, 1'b1);
        send_byte(8'h33, 1'b1);
        drain_lines();
        cfg_write(UNUSED_ADDR, 32'h0000_0000);
        send_byte(8'h80, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(ESC_BYTE, 1'b1);

        tx_idle_pct <= 15;
        rx_idle_pct <= 51;
        send_random_frames(70);
        drain_lines();
        cfg_write(OPEN_FLAG_ADDR, $urandom);

        tx_idle_pct <= 51;
        rx_idle_pct <= 15;
        send_random_frames(70);
        drain_lines();
        cfg_write(OPEN_FLAG_ADDR, 32'h0000_0000);

        tx_idle_pct   <= 0;
        rx_idle_pct   <= 0;
        hold_requests <= hold_requests + 1;
        send_random_frames(40);
        drain_lines();
        cfg_write(OPEN_FLAG_ADDR, 32'h0000_0001);
        send_random_frames(30);

        drain_lines();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
